>>> hdl/sla_pkg.sv
// shared codes and constants for the local sequence alignment unit
// no dependencies
package sla_pkg;

    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int CFG_W  = 8;
    localparam int CIDX_W = 2;
    localparam int BEST_W = 15;
    localparam int PATH_W = 18;

    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_ALIGN         = 2'd2;

    localparam logic [CIDX_W-1:0] REG_MATCH    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MISMATCH = 2'd1;
    localparam logic [CIDX_W-1:0] REG_GAP      = 2'd2;

    localparam logic signed [CFG_W-1:0] MATCH_RST    = 8'sd1;
    localparam logic signed [CFG_W-1:0] MISMATCH_RST = -8'sd1;
    localparam logic signed [CFG_W-1:0] GAP_RST      = -8'sd2;

    localparam logic [1:0] DIR_DIAG = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;

endpackage

>>> hdl/sla_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/local_sequence_alignment_unit.sv
// top level of the local sequence alignment unit (smith-waterman, linear gap)
// depends on sla_pkg and sla_ram
//
// Appends are taken while the sequencer is idle. An align beat fills the m x n
// score matrix one cell at a time through a single add/max/saturate unit, each
// cell passing through read, add and write states, then walks the traceback,
// reading a cell and writing one path entry per step, and streams the path, with
// a read and a load per output beat, held by any output stall. s_tready is high
// only while the sequencer is idle. The score matrix memory holds direction and
// score per cell; row and column zero are never stored.
module local_sequence_alignment_unit #(
    parameter int MAX_LEN     = 32,
    parameter int SCORE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // top_symbol, top_is_gap, bottom_symbol, bottom_is_gap,
                                   // best_score, zero pad
    output logic [0:0]  m_tuser,   // empty_res
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int SW   = SCORE_WIDTH;
    localparam int IW   = $clog2(MAX_LEN + 1);
    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PD   = 2 * MAX_LEN;
    localparam int PW   = $clog2(PD);
    localparam int MD   = 1 << (2 * IW);
    localparam int MW   = SW - 1 + 2;
    localparam int CW   = sla_pkg::CFG_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_F_RD  = 4'd1;
    localparam logic [3:0] ST_F_ADD = 4'd2;
    localparam logic [3:0] ST_F_WR  = 4'd3;
    localparam logic [3:0] ST_T_RD  = 4'd4;
    localparam logic [3:0] ST_T_WB  = 4'd5;
    localparam logic [3:0] ST_E_RD  = 4'd6;
    localparam logic [3:0] ST_E_LD  = 4'd7;
    localparam logic [3:0] ST_EMPTY = 4'd8;

    localparam logic signed [SW:0] TOP = {2'b00, {(SW-1){1'b1}}};

    logic [3:0]  state_reg, state_next;
    logic [IW-1:0] len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, bi_reg, bi_next, bj_reg, bj_next;
    logic [SW-2:0] best_reg, best_next, left_reg, left_next, updiag_reg, updiag_next;
    logic signed [SW:0] d_reg, d_next, u_reg, u_next, l_reg, l_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic signed [CW-1:0] match_reg, mismatch_reg, gap_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  o_top_reg, o_top_next, o_bot_reg, o_bot_next;
    logic        o_tg_reg, o_tg_next, o_bg_reg, o_bg_next, o_emp_reg, o_emp_next;
    logic        o_last_reg, o_last_next;
    logic [sla_pkg::BEST_W-1:0] o_best_reg, o_best_next;

    logic            a_we, b_we, m_we, p_we;
    logic [AW-1:0]   a_waddr, b_waddr, a_raddr, b_raddr;
    logic [7:0]      a_rdata, b_rdata;
    logic [2*IW-1:0] m_waddr, m_raddr;
    logic [MW-1:0]   m_wdata, m_rdata;
    logic [PW-1:0]   p_waddr;
    logic [sla_pkg::PATH_W-1:0] p_wdata, p_rdata;

    logic            accept;
    logic [IW-1:0]   i_m1, j_m1;
    logic [SW-2:0]   up_val, diag_val, left_val, sat;
    logic signed [SW:0] mx, sat_s, s_ext, g_ext;
    logic [1:0]      dir;
    logic            out_free;
    logic [SW+13:0]  best_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign i_m1     = i_reg - IW'(1);
    assign j_m1     = j_reg - IW'(1);
    assign out_free = !out_valid_reg || m_tready;

    // memories
    assign a_we    = accept && (s_tuser == sla_pkg::OP_APPEND_FIRST) && (len_a_reg < IW'(MAX_LEN));
    assign b_we    = accept && (s_tuser == sla_pkg::OP_APPEND_SECOND) && (len_b_reg < IW'(MAX_LEN));
    assign a_waddr = len_a_reg[AW-1:0];
    assign b_waddr = len_b_reg[AW-1:0];
    assign a_raddr = j_m1[AW-1:0];
    assign b_raddr = i_m1[AW-1:0];
    assign m_raddr = (state_reg == ST_F_RD) ? {i_m1, j_reg} : {i_reg, j_reg};
    assign m_waddr = {i_reg, j_reg};
    assign m_we    = (state_reg == ST_F_WR);
    assign m_wdata = {dir, sat};
    assign p_we    = (state_reg == ST_T_WB) && (m_rdata[SW-2:0] != '0);
    assign p_waddr = cnt_reg[PW-1:0];

    always_comb
    begin
        unique case (m_rdata[MW-1:MW-2])
            sla_pkg::DIR_DIAG: p_wdata = {2'b00, a_rdata, b_rdata};
            sla_pkg::DIR_UP:   p_wdata = {2'b10, 8'd0, b_rdata};
            default:           p_wdata = {2'b01, a_rdata, 8'd0};
        endcase
    end

    sla_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(s_tdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    sla_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(s_tdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    sla_ram #(.WIDTH(MW), .DEPTH(MD)) u_matrix_ram (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    sla_ram #(.WIDTH(sla_pkg::PATH_W), .DEPTH(PD)) u_path_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(ptr_reg), .rdata(p_rdata)
    );

    // shared cell unit
    assign up_val   = (i_reg == IW'(1)) ? '0 : m_rdata[SW-2:0];
    assign diag_val = (i_reg == IW'(1) || j_reg == IW'(1)) ? '0 : updiag_reg;
    assign left_val = (j_reg == IW'(1)) ? '0 : left_reg;
    assign s_ext    = (a_rdata == b_rdata) ? (SW+1)'(match_reg) : (SW+1)'(mismatch_reg);
    assign g_ext    = (SW+1)'(gap_reg);

    always_comb
    begin
        mx = d_reg;
        if (u_reg > mx)
        begin
            mx = u_reg;
        end
        if (l_reg > mx)
        begin
            mx = l_reg;
        end
    end

    assign sat   = (mx < 0) ? '0 : ((mx > TOP) ? {(SW-1){1'b1}} : mx[SW-2:0]);
    assign sat_s = {2'b00, sat};

    always_comb
    begin
        priority if (sat_s == d_reg)
            dir = sla_pkg::DIR_DIAG;
        else if (sat_s == u_reg)
            dir = sla_pkg::DIR_UP;
        else
            dir = sla_pkg::DIR_LEFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= sla_pkg::MATCH_RST;
            mismatch_reg <= sla_pkg::MISMATCH_RST;
            gap_reg      <= sla_pkg::GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sla_pkg::REG_MATCH:    match_reg    <= cfg_data;
                sla_pkg::REG_MISMATCH: mismatch_reg <= cfg_data;
                sla_pkg::REG_GAP:      gap_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        bi_next        = bi_reg;
        bj_next        = bj_reg;
        best_next      = best_reg;
        left_next      = left_reg;
        updiag_next    = updiag_reg;
        d_next         = d_reg;
        u_next         = u_reg;
        l_next         = l_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        o_top_next     = o_top_reg;
        o_bot_next     = o_bot_reg;
        o_tg_next      = o_tg_reg;
        o_bg_next      = o_bg_reg;
        o_emp_next     = o_emp_reg;
        o_last_next    = o_last_reg;
        o_best_next    = o_best_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (a_we)
                begin
                    len_a_next = len_a_reg + IW'(1);
                end
                if (b_we)
                begin
                    len_b_next = len_b_reg + IW'(1);
                end
                if (accept && s_tuser == sla_pkg::OP_ALIGN)
                begin
                    best_next = '0;
                    bi_next   = '0;
                    bj_next   = '0;
                    i_next    = IW'(1);
                    j_next    = IW'(1);
                    cnt_next  = '0;
                    if (len_a_reg == '0 || len_b_reg == '0)
                        state_next = ST_EMPTY;
                    else
                        state_next = ST_F_RD;
                end
            end
            ST_F_RD:
            begin
                state_next = ST_F_ADD;
            end
            ST_F_ADD:
            begin
                d_next      = $signed({2'b00, diag_val}) + s_ext;
                u_next      = $signed({2'b00, up_val}) + g_ext;
                l_next      = $signed({2'b00, left_val}) + g_ext;
                updiag_next = up_val;
                state_next  = ST_F_WR;
            end
            ST_F_WR:
            begin
                left_next = sat;
                if (sat >= best_reg)
                begin
                    best_next = sat;
                    bi_next   = i_reg;
                    bj_next   = j_reg;
                end
                if (j_reg == len_a_reg)
                begin
                    j_next = IW'(1);
                    if (i_reg == len_b_reg)
                    begin
                        if (sat >= best_reg)
                        begin
                            i_next = i_reg;
                            j_next = j_reg;
                        end
                        else
                        begin
                            i_next = bi_reg;
                            j_next = bj_reg;
                        end
                        if (sat == '0 && best_reg == '0)
                            state_next = ST_EMPTY;
                        else
                            state_next = ST_T_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = ST_F_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_F_RD;
                end
            end
            ST_T_RD:
            begin
                if (i_reg == '0 || j_reg == '0)
                begin
                    ptr_next   = PW'(cnt_reg - (PW+1)'(1));
                    state_next = ST_E_RD;
                end
                else
                begin
                    state_next = ST_T_WB;
                end
            end
            ST_T_WB:
            begin
                if (m_rdata[SW-2:0] == '0)
                begin
                    ptr_next   = PW'(cnt_reg - (PW+1)'(1));
                    state_next = ST_E_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + (PW+1)'(1);
                    unique case (m_rdata[MW-1:MW-2])
                        sla_pkg::DIR_DIAG:
                        begin
                            i_next = i_m1;
                            j_next = j_m1;
                        end
                        sla_pkg::DIR_UP:   i_next = i_m1;
                        default:           j_next = j_m1;
                    endcase
                    state_next = ST_T_RD;
                end
            end
            ST_E_RD:
            begin
                state_next = ST_E_LD;
            end
            ST_E_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_tg_next      = p_rdata[17];
                    o_bg_next      = p_rdata[16];
                    o_top_next     = p_rdata[15:8];
                    o_bot_next     = p_rdata[7:0];
                    o_emp_next     = 1'b0;
                    o_last_next    = (ptr_reg == '0);
                    o_best_next    = best_ext[sla_pkg::BEST_W-1:0];
                    if (ptr_reg == '0)
                    begin
                        len_a_next = '0;
                        len_b_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - PW'(1);
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_tg_next      = 1'b0;
                    o_bg_next      = 1'b0;
                    o_top_next     = '0;
                    o_bot_next     = '0;
                    o_emp_next     = 1'b1;
                    o_last_next    = 1'b1;
                    o_best_next    = '0;
                    best_next      = '0;
                    len_a_next     = '0;
                    len_b_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        bi_reg     <= bi_next;
        bj_reg     <= bj_next;
        best_reg   <= best_next;
        left_reg   <= left_next;
        updiag_reg <= updiag_next;
        d_reg      <= d_next;
        u_reg      <= u_next;
        l_reg      <= l_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
        o_top_reg  <= o_top_next;
        o_bot_reg  <= o_bot_next;
        o_tg_reg   <= o_tg_next;
        o_bg_reg   <= o_bg_next;
        o_emp_reg  <= o_emp_next;
        o_last_reg <= o_last_next;
        o_best_reg <= o_best_next;
    end

    assign best_ext = {15'd0, best_reg};
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, o_best_reg, o_bg_reg, o_bot_reg,
                       o_tg_reg, o_top_reg};
    assign m_tuser  = o_emp_reg;
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("empty beat without tlast");

    a_fill_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_F_WR |-> (i_reg != '0) && (j_reg != '0)
            && (i_reg <= len_b_reg) && (j_reg <= len_a_reg))
        else $error("fill index outside matrix");

    a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_T_WB |-> cnt_reg < (PW+1)'(PD))
        else $error("path overflow");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len_a_reg <= IW'(MAX_LEN)) && (len_b_reg <= IW'(MAX_LEN)))
        else $error("sequence length beyond maximum");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_E_LD && out_free && ptr_reg == '0 |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after final beat");
`endif

endmodule
